>>> hw/rtl/sll_pkg.sv
package sll_pkg;

	// fixed field widths
	localparam int unsigned LEN_W = 12;
	localparam int unsigned LEN_MAX = 4095;
	localparam int unsigned MAX_TOKEN_LEN_DEF = 4095;

	// result queue depth, a power of two and at least two
	localparam int unsigned OUTQ_DEPTH = 4;

	typedef logic [LEN_W-1:0] len_t;

	// token kinds as seen on the result channel
	typedef enum logic [2:0] {
		K_WORD    = 3'd0,
		K_PIPE    = 3'd1,
		K_IN      = 3'd2,
		K_OUT     = 3'd3,
		K_HEREDOC = 3'd4,
		K_APPEND  = 3'd5,
		K_END     = 3'd6
	} kind_t;

	// lexer modes, one-hot
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WORD  = 5'b00010,
		ST_QUOTE = 5'b00100,
		ST_LT    = 5'b01000,
		ST_GT    = 5'b10000
	} mode_t;

	// special bytes
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// input request
	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_end;
	} cmd_t;

	// result request
	typedef struct packed {
		kind_t token_kind;
		len_t  token_length;
		logic  unclosed_quote;
		logic  last_of_run;
	} tok_t;

	// up to two results pushed into the queue in one cycle
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       r0;
		tok_t       r1;
	} push_t;

	function automatic tok_t make_tok(kind_t kind, len_t len, logic unc);
		tok_t t;
		t.token_kind     = kind;
		t.token_length   = len;
		t.unclosed_quote = unc;
		t.last_of_run    = 1'b0;
		return t;
	endfunction

endpackage

>>> hw/rtl/sll_core.sv
module sll_core #(
	parameter int unsigned MAX_TOKEN_LEN = sll_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  sll_pkg::cmd_t  item,
	output sll_pkg::push_t push
);

	localparam int unsigned CAP_INT =
		(MAX_TOKEN_LEN < sll_pkg::LEN_MAX) ? MAX_TOKEN_LEN : sll_pkg::LEN_MAX;
	localparam sll_pkg::len_t LEN_CAP = sll_pkg::len_t'(CAP_INT);

	sll_pkg::mode_t mode_q, nx_mode, id_mode;
	logic           qd_q, nx_qd, id_qd;
	sll_pkg::len_t  len_q, nx_len, id_len, len_inc;

	logic [7:0] b;
	logic       is_sp, is_pipe, is_lt, is_gt, is_sq, is_dq, is_delim, id_pipe, unc;
	logic [1:0] n;
	sll_pkg::tok_t e0, e1, end_rec;

	// byte classes
	assign b        = item.char_byte;
	assign is_sp    = (b == sll_pkg::CH_SPACE) || (b inside {[8'd9:8'd13]});
	assign is_pipe  = (b == sll_pkg::CH_PIPE);
	assign is_lt    = (b == sll_pkg::CH_LT);
	assign is_gt    = (b == sll_pkg::CH_GT);
	assign is_sq    = (b == sll_pkg::CH_SQUOT);
	assign is_dq    = (b == sll_pkg::CH_DQUOT);
	assign is_delim = is_sp || is_pipe || is_lt || is_gt;

	// saturating length step
	assign len_inc = (len_q < LEN_CAP) ? len_q + sll_pkg::len_t'(1) : LEN_CAP;

	// what a byte does when seen between tokens
	always_comb begin
		id_mode = sll_pkg::ST_WORD;
		id_len  = sll_pkg::len_t'(1);
		id_qd   = qd_q;
		id_pipe = 1'b0;
		if (is_sp) begin
			id_mode = sll_pkg::ST_IDLE;
			id_len  = '0;
		end else if (is_pipe) begin
			id_mode = sll_pkg::ST_IDLE;
			id_len  = '0;
			id_pipe = 1'b1;
		end else if (is_lt) begin
			id_mode = sll_pkg::ST_LT;
			id_len  = '0;
		end else if (is_gt) begin
			id_mode = sll_pkg::ST_GT;
			id_len  = '0;
		end else if (is_sq || is_dq) begin
			id_mode = sll_pkg::ST_QUOTE;
			id_qd   = is_dq;
		end
	end

	// one step of the lexer: next state and up to two tokens
	always_comb begin
		nx_mode = mode_q;
		nx_qd   = qd_q;
		nx_len  = len_q;
		n       = 2'd0;
		unc     = 1'b0;
		e0      = '0;
		e1      = '0;
		end_rec = '0;
		if (item.line_end) begin
			case (mode_q)
				sll_pkg::ST_WORD: begin
					e0 = sll_pkg::make_tok(sll_pkg::K_WORD, len_q, 1'b0);
					n  = 2'd1;
				end
				sll_pkg::ST_QUOTE: begin
					e0  = sll_pkg::make_tok(sll_pkg::K_WORD, len_q, 1'b0);
					n   = 2'd1;
					unc = 1'b1;
				end
				sll_pkg::ST_LT: begin
					e0 = sll_pkg::make_tok(sll_pkg::K_IN, sll_pkg::len_t'(1), 1'b0);
					n  = 2'd1;
				end
				sll_pkg::ST_GT: begin
					e0 = sll_pkg::make_tok(sll_pkg::K_OUT, sll_pkg::len_t'(1), 1'b0);
					n  = 2'd1;
				end
				default: begin
					n = 2'd0;
				end
			endcase
			// end record follows any flushed token
			end_rec = sll_pkg::make_tok(sll_pkg::K_END, '0, unc);
			if (n == 2'd1) begin
				e1 = end_rec;
				n  = 2'd2;
			end else begin
				e0 = end_rec;
				n  = 2'd1;
			end
			nx_mode = sll_pkg::ST_IDLE;
			nx_qd   = 1'b0;
			nx_len  = '0;
		end else begin
			case (mode_q)
				sll_pkg::ST_WORD: begin
					if (is_delim) begin
						e0      = sll_pkg::make_tok(sll_pkg::K_WORD, len_q, 1'b0);
						n       = 2'd1;
						if (id_pipe) begin
							e1 = sll_pkg::make_tok(sll_pkg::K_PIPE, sll_pkg::len_t'(1), 1'b0);
							n  = 2'd2;
						end
						nx_mode = id_mode;
						nx_qd   = id_qd;
						nx_len  = id_len;
					end else begin
						nx_len = len_inc;
						if (is_sq || is_dq) begin
							nx_qd   = is_dq;
							nx_mode = sll_pkg::ST_QUOTE;
						end
					end
				end
				sll_pkg::ST_QUOTE: begin
					nx_len = len_inc;
					if ((qd_q && is_dq) || (!qd_q && is_sq)) begin
						nx_mode = sll_pkg::ST_WORD;
					end
				end
				sll_pkg::ST_LT: begin
					if (is_lt) begin
						e0      = sll_pkg::make_tok(sll_pkg::K_HEREDOC, sll_pkg::len_t'(2), 1'b0);
						n       = 2'd1;
						nx_mode = sll_pkg::ST_IDLE;
					end else begin
						e0      = sll_pkg::make_tok(sll_pkg::K_IN, sll_pkg::len_t'(1), 1'b0);
						n       = 2'd1;
						if (id_pipe) begin
							e1 = sll_pkg::make_tok(sll_pkg::K_PIPE, sll_pkg::len_t'(1), 1'b0);
							n  = 2'd2;
						end
						nx_mode = id_mode;
						nx_qd   = id_qd;
						nx_len  = id_len;
					end
				end
				sll_pkg::ST_GT: begin
					if (is_gt) begin
						e0      = sll_pkg::make_tok(sll_pkg::K_APPEND, sll_pkg::len_t'(2), 1'b0);
						n       = 2'd1;
						nx_mode = sll_pkg::ST_IDLE;
					end else begin
						e0      = sll_pkg::make_tok(sll_pkg::K_OUT, sll_pkg::len_t'(1), 1'b0);
						n       = 2'd1;
						if (id_pipe) begin
							e1 = sll_pkg::make_tok(sll_pkg::K_PIPE, sll_pkg::len_t'(1), 1'b0);
							n  = 2'd2;
						end
						nx_mode = id_mode;
						nx_qd   = id_qd;
						nx_len  = id_len;
					end
				end
				default: begin
					if (id_pipe) begin
						e0 = sll_pkg::make_tok(sll_pkg::K_PIPE, sll_pkg::len_t'(1), 1'b0);
						n  = 2'd1;
					end
					nx_mode = id_mode;
					nx_qd   = id_qd;
					nx_len  = id_len;
				end
			endcase
		end
		// mark the final token of this byte
		if (n == 2'd1) begin
			e0.last_of_run = 1'b1;
		end
		if (n == 2'd2) begin
			e1.last_of_run = 1'b1;
		end
	end

	// tokens go to the queue only when the step is taken
	always_comb begin
		push.cnt = fire ? n : 2'd0;
		push.r0  = e0;
		push.r1  = e1;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sll_pkg::ST_IDLE;
			qd_q   <= 1'b0;
			len_q  <= '0;
		end else if (fire) begin
			mode_q <= nx_mode;
			qd_q   <= nx_qd;
			len_q  <= nx_len;
		end
	end

endmodule

>>> hw/rtl/sll_outq.sv
module sll_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  sll_pkg::push_t push,
	output logic           room,
	output logic           tok_valid,
	input  logic           tok_stall,
	output sll_pkg::tok_t  tok
);

	localparam int unsigned PTR_W = $clog2(sll_pkg::OUTQ_DEPTH);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [PTR_W:0]   cnt_t;

	sll_pkg::tok_t mem [sll_pkg::OUTQ_DEPTH];
	ptr_t wr_q, rd_q;
	cnt_t cnt_q;
	logic pop;

	assign pop       = tok_valid && !tok_stall;
	assign tok_valid = (cnt_q != '0);
	assign tok       = mem[rd_q];
	// space for the worst case of two tokens from one byte
	assign room      = (cnt_q <= cnt_t'(sll_pkg::OUTQ_DEPTH - 2));

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + ptr_t'(push.cnt);
			rd_q  <= rd_q + ptr_t'(pop);
			cnt_q <= cnt_q + cnt_t'(push.cnt) - cnt_t'(pop);
		end
	end

	// token storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + ptr_t'(1)] <= push.r1;
		end
	end

endmodule

>>> hw/rtl/shell_line_lexer.sv
// shell_line_lexer: command-line tokenizer
//
// cmd channel: one request per byte of the command line (char_byte), or a
// line-end request (line_end = 1) that flushes the pending token and adds an
// end-of-line record. tok channel: one request per token as it closes, with
// kind, length in bytes (quotes included, saturating), the unclosed-quote
// flag on the end record, and last_of_run on the final token of a byte.
// A request moves when valid is high and stall is low.
// Path: a taken byte is held in the input register and lexed from there; its
// tokens are written into the result queue and offered on tok from the queue.
// Throughput: one byte per cycle while the result queue has room for two
// tokens; tok hands out a single token at a time through the single read
// port of the result queue, so bytes that close two tokens fill the queue
// until cmd_stall holds the input.
// A stalled tok request holds; the queue keeps taking bytes until it lacks
// room for two tokens, then cmd_stall rises.
// Reset clears the lexer to idle between tokens and empties the queue.
module shell_line_lexer #(
	parameter int unsigned MAX_TOKEN_LEN = sll_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  sll_pkg::cmd_t cmd,
	output logic          tok_valid,
	input  logic          tok_stall,
	output sll_pkg::tok_t tok
);

	logic           cmd_valid_s1;
	sll_pkg::cmd_t  cmd_s1;
	logic           room, fire, take;
	sll_pkg::push_t push;

	assign fire      = cmd_valid_s1 && room;
	assign cmd_stall = cmd_valid_s1 && !room;
	assign take      = cmd_valid && !cmd_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (take) begin
			cmd_valid_s1 <= 1'b1;
		end else if (fire) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
	end

	sll_core #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (cmd_s1),
		.push  (push)
	);

	sll_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok      (tok)
	);

endmodule

>>> hw/rtl/sll_checker.sv
module sll_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          tok_valid,
	input logic          tok_stall,
	input sll_pkg::tok_t tok
);

	// a stalled token holds
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok))
		else $error("token changed while stalled");

	// end record carries no length and closes the run
	a_end_rec: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok.token_kind == sll_pkg::K_END |->
		tok.token_length == '0 && tok.last_of_run)
		else $error("bad end record");

	// unclosed quote only on the end record
	a_unc_end: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok.token_kind != sll_pkg::K_END |-> !tok.unclosed_quote)
		else $error("unclosed quote flag on a token");

	// operator lengths follow their form
	a_op_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok.token_kind == sll_pkg::K_PIPE ||
		tok.token_kind == sll_pkg::K_IN || tok.token_kind == sll_pkg::K_OUT) |->
		tok.token_length == sll_pkg::len_t'(1))
		else $error("single operator length wrong");

	a_dop_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok.token_kind == sll_pkg::K_HEREDOC ||
		tok.token_kind == sll_pkg::K_APPEND) |->
		tok.token_length == sll_pkg::len_t'(2))
		else $error("double operator length wrong");

endmodule

bind shell_line_lexer sll_checker u_sll_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.tok_valid(tok_valid),
	.tok_stall(tok_stall),
	.tok      (tok)
);
